[design/wia_pkg.sv]
// Shared constants and types for the wide integer ALU.
`default_nettype none
package wia_pkg;

    localparam int FIELD_BITS = 64;
    localparam int FULL_BITS  = 128;
    localparam int OP_BITS    = 4;
    localparam int SHIFT_BITS = 8;

    localparam logic [OP_BITS-1:0] OP_ADD = 4'd0;
    localparam logic [OP_BITS-1:0] OP_SUB = 4'd1;
    localparam logic [OP_BITS-1:0] OP_AND = 4'd2;
    localparam logic [OP_BITS-1:0] OP_OR  = 4'd3;
    localparam logic [OP_BITS-1:0] OP_XOR = 4'd4;
    localparam logic [OP_BITS-1:0] OP_NOT = 4'd5;
    localparam logic [OP_BITS-1:0] OP_SHL = 4'd6;
    localparam logic [OP_BITS-1:0] OP_SAR = 4'd7;
    localparam logic [OP_BITS-1:0] OP_MUL = 4'd8;
    localparam logic [OP_BITS-1:0] OP_DIV = 4'd9;

    // How the back end treats an item.
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_MUL,
        KIND_DIV
    } t_kind;

    // Control word that travels with each item down the iteration pipeline.
    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  neg;
        logic  dz;
    } t_ctl;

endpackage
`default_nettype wire

[design/wia_front.sv]
// Front end: takes input transfers, trims operands and classifies the operation.
`default_nettype none
module wia_front #(
    parameter int W = 128
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [wia_pkg::OP_BITS-1:0]      i_operation,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_a_high,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_a_low,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_b_high,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_b_low,
    input  wire  [wia_pkg::SHIFT_BITS-1:0]   i_shift_amount,
    input  wire                              i_q_full,
    output logic                             o_push,
    output wia_pkg::t_kind                   o_kind,
    output logic [wia_pkg::OP_BITS-1:0]      o_op,
    output logic [wia_pkg::SHIFT_BITS-1:0]   o_sh,
    output logic [W-1:0]                     o_a,
    output logic [W-1:0]                     o_b,
    output logic                             o_bz
);
    import wia_pkg::*;

    logic                   r_valid;
    t_kind                  r_kind;
    t_kind                  n_kind;
    logic [OP_BITS-1:0]     r_op;
    logic [SHIFT_BITS-1:0]  r_sh;
    logic [W-1:0]           r_a;
    logic [W-1:0]           r_b;
    logic                   r_bz;
    logic [FULL_BITS-1:0]   a_cat;
    logic [FULL_BITS-1:0]   b_cat;
    logic                   load;

    assign a_cat = {i_operand_a_high, i_operand_a_low};
    assign b_cat = {i_operand_b_high, i_operand_b_low};

    // The holding register frees up when its item moves into the queue.
    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign load       = i_in_valid && !o_in_stall;

    // Sort the operation into the way the back end will run it.
    always_comb begin
        case (i_operation)
            OP_MUL:  n_kind = KIND_MUL;
            OP_DIV:  n_kind = KIND_DIV;
            default: n_kind = KIND_PASS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_op   <= i_operation;
            r_sh   <= i_shift_amount;
            r_a    <= a_cat[W-1:0];
            r_b    <= b_cat[W-1:0];
            r_bz   <= (b_cat[W-1:0] == '0);
        end
    end

    assign o_kind = r_kind;
    assign o_op   = r_op;
    assign o_sh   = r_sh;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_bz   = r_bz;

endmodule
`default_nettype wire

[design/wia_fifo.sv]
// Short queue between the front end and the back end.
`default_nettype none
module wia_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd];

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

[design/wia_stage.sv]
// One iteration stage: a shift-add multiply step or a restoring divide step.
`default_nettype none
module wia_stage #(
    parameter int W = 128
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  wire  wia_pkg::t_ctl i_ctl,
    input  wire  [W-1:0]    i_x,
    input  wire  [W-1:0]    i_y,
    input  wire  [W-1:0]    i_p,
    input  wire  [W-1:0]    i_q,
    output wia_pkg::t_ctl   o_ctl,
    output logic [W-1:0]    o_x,
    output logic [W-1:0]    o_y,
    output logic [W-1:0]    o_p,
    output logic [W-1:0]    o_q
);
    import wia_pkg::*;

    t_ctl         r_ctl;
    logic [W-1:0] r_x;
    logic [W-1:0] r_y;
    logic [W-1:0] r_p;
    logic [W-1:0] r_q;
    logic [W-1:0] n_x;
    logic [W-1:0] n_y;
    logic [W-1:0] n_p;
    logic [W-1:0] n_q;
    logic [W-1:0] trial;
    logic         fits;

    // Divide: bring down the next numerator bit and try the subtraction.
    assign trial = {i_p[W-2:0], i_x[W-1]};
    assign fits  = (trial >= i_y);

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_p = i_p;
        n_q = i_q;
        case (i_ctl.kind)
            KIND_MUL: begin
                // Add the multiplicand where the current multiplier bit is set.
                n_p = i_y[0] ? (i_p + i_x) : i_p;
                n_x = i_x << 1;
                n_y = i_y >> 1;
            end
            KIND_DIV: begin
                n_p = fits ? (trial - i_y) : trial;
                n_q = {i_q[W-2:0], fits};
                n_x = i_x << 1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_p <= n_p;
            r_q <= n_q;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_p   = r_p;
    assign o_q   = r_q;

endmodule
`default_nettype wire

[design/wia_back.sv]
// Back end: operand preparation, the iteration pipeline and the output register.
`default_nettype none
module wia_back #(
    parameter int W = 128
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_pop,
    input  wire  wia_pkg::t_kind             i_kind,
    input  wire  [wia_pkg::OP_BITS-1:0]      i_op,
    input  wire  [wia_pkg::SHIFT_BITS-1:0]   i_sh,
    input  wire  [W-1:0]                     i_a,
    input  wire  [W-1:0]                     i_b,
    input  wire                              i_bz,
    input  wire                              i_out_stall,
    output logic                             o_out_valid,
    output logic [W-1:0]                     o_res,
    output logic                             o_dz
);
    import wia_pkg::*;

    t_ctl                  s_ctl [W+1];
    logic [W-1:0]          s_x   [W+1];
    logic [W-1:0]          s_y   [W+1];
    logic [W-1:0]          s_p   [W+1];
    logic [W-1:0]          s_q   [W+1];

    t_ctl                  r_ctl0;
    logic [W-1:0]          r_x0;
    logic [W-1:0]          r_y0;
    logic [W-1:0]          r_p0;
    t_ctl                  n_ctl0;
    logic [W-1:0]          n_x0;
    logic [W-1:0]          n_y0;
    logic [W-1:0]          n_p0;
    logic [W-1:0]          simple;
    logic [SHIFT_BITS-1:0] sar_n;
    logic                  sh_big;
    logic [W-1:0]          mag_a;
    logic [W-1:0]          mag_b;

    logic                  r_out_valid;
    logic [W-1:0]          r_res;
    logic                  r_dz;
    logic [W-1:0]          n_res;
    logic                  adv;

    // The whole pipeline moves whenever the output register can take a word.
    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = adv && i_valid;

    // Simple operations, computed ahead of the operand register.
    assign sh_big = (32'(i_sh) >= W);
    assign sar_n  = sh_big ? SHIFT_BITS'(W - 1) : i_sh;

    always_comb begin
        case (i_op)
            OP_ADD:  simple = i_a + i_b;
            OP_SUB:  simple = i_a - i_b;
            OP_AND:  simple = i_a & i_b;
            OP_OR:   simple = i_a | i_b;
            OP_XOR:  simple = i_a ^ i_b;
            OP_NOT:  simple = ~i_a;
            OP_SHL:  simple = sh_big ? '0 : (i_a << i_sh);
            OP_SAR:  simple = W'($signed(i_a) >>> sar_n);
            default: simple = '0;
        endcase
    end

    // Magnitudes for the divide; the most negative value is its own magnitude.
    assign mag_a = i_a[W-1] ? ('0 - i_a) : i_a;
    assign mag_b = i_b[W-1] ? ('0 - i_b) : i_b;

    always_comb begin
        n_ctl0.valid = i_valid;
        n_ctl0.kind  = i_kind;
        n_ctl0.neg   = i_a[W-1] ^ i_b[W-1];
        n_ctl0.dz    = (i_kind == KIND_DIV) && i_bz;
        case (i_kind)
            KIND_MUL: begin
                n_x0 = i_a;
                n_y0 = i_b;
                n_p0 = '0;
            end
            KIND_DIV: begin
                n_x0 = mag_a;
                n_y0 = mag_b;
                n_p0 = '0;
            end
            default: begin
                n_x0 = i_a;
                n_y0 = i_b;
                n_p0 = simple;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (adv) begin
            r_ctl0 <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
            r_p0 <= n_p0;
        end
    end

    assign s_ctl[0] = r_ctl0;
    assign s_x[0]   = r_x0;
    assign s_y[0]   = r_y0;
    assign s_p[0]   = r_p0;
    assign s_q[0]   = '0;

    // One multiply or divide bit per stage.
    for (genvar k = 0; k < W; k++) begin : g_stage
        wia_stage #(.W(W)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_ctl   (s_ctl[k]),
            .i_x     (s_x[k]),
            .i_y     (s_y[k]),
            .i_p     (s_p[k]),
            .i_q     (s_q[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_x     (s_x[k+1]),
            .o_y     (s_y[k+1]),
            .o_p     (s_p[k+1]),
            .o_q     (s_q[k+1])
        );
    end

    // Pick the finished word; a quotient takes its sign here.
    always_comb begin
        case (s_ctl[W].kind)
            KIND_DIV: begin
                if (s_ctl[W].dz) begin
                    n_res = '0;
                end else begin
                    n_res = s_ctl[W].neg ? ('0 - s_q[W]) : s_q[W];
                end
            end
            default: n_res = s_p[W];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= s_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
            r_dz  <= s_ctl[W].dz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign o_dz        = r_dz;

endmodule
`default_nettype wire

[design/wide_integer_alu_core.sv]
// Top level of the wide integer ALU: front end, queue and back end.
//
// Usage: an item (operation, two operands in high and low halves, shift
// amount) transfers on the input channel when i_in_valid is high and
// o_in_stall is low. Each item gives exactly one result word with a
// divide-by-zero flag, which transfers when o_out_valid is high and
// i_out_stall is low. Results leave in the order the items came in.
// Every operation runs through the same pipeline of WORD_BITS iteration
// stages, one multiply or divide bit per stage; ahead of it lie the front
// register, the queue and the operand register, and behind it the output
// register. One item is taken every cycle when nothing stalls.
// When the receiver stalls, the output register holds its word and the
// pipeline freezes; the queue of QUEUE_DEPTH entries then fills and the
// input channel stalls once the front register is also occupied.
// Reset clears every valid flag and the queue; no item is in flight after it.
`default_nettype none
module wide_integer_alu_core #(
    parameter int WORD_BITS   = 128,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [wia_pkg::OP_BITS-1:0]      i_operation,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_a_high,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_a_low,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_b_high,
    input  wire  [wia_pkg::FIELD_BITS-1:0]   i_operand_b_low,
    input  wire  [wia_pkg::SHIFT_BITS-1:0]   i_shift_amount,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [wia_pkg::FIELD_BITS-1:0]   o_result_high,
    output logic [wia_pkg::FIELD_BITS-1:0]   o_result_low,
    output logic                             o_divide_by_zero
);
    import wia_pkg::*;

    typedef struct packed {
        t_kind                 kind;
        logic [OP_BITS-1:0]    op;
        logic [SHIFT_BITS-1:0] sh;
        logic [WORD_BITS-1:0]  a;
        logic [WORD_BITS-1:0]  b;
        logic                  bz;
    } t_entry;

    t_entry                 push_entry;
    t_entry                 pop_entry;
    logic                   push;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;
    logic [WORD_BITS-1:0]   res;
    logic [FULL_BITS-1:0]   res_full;

    wia_front #(.W(WORD_BITS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_operand_a_high (i_operand_a_high),
        .i_operand_a_low  (i_operand_a_low),
        .i_operand_b_high (i_operand_b_high),
        .i_operand_b_low  (i_operand_b_low),
        .i_shift_amount   (i_shift_amount),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_kind           (push_entry.kind),
        .o_op             (push_entry.op),
        .o_sh             (push_entry.sh),
        .o_a              (push_entry.a),
        .o_b              (push_entry.b),
        .o_bz             (push_entry.bz)
    );

    wia_fifo #(.WIDTH($bits(t_entry)), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wia_back #(.W(WORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .o_pop       (pop),
        .i_kind      (pop_entry.kind),
        .i_op        (pop_entry.op),
        .i_sh        (pop_entry.sh),
        .i_a         (pop_entry.a),
        .i_b         (pop_entry.b),
        .i_bz        (pop_entry.bz),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (res),
        .o_dz        (o_divide_by_zero)
    );

    // Widen the word to the fixed result halves.
    assign res_full      = FULL_BITS'(res);
    assign o_result_high = res_full[FULL_BITS-1:FIELD_BITS];
    assign o_result_low  = res_full[FIELD_BITS-1:0];

`ifndef ASSERT_OFF
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_by_zero) |-> (res == '0))
        else $error("divide by zero flagged with a nonzero result");
`endif

endmodule
`default_nettype wire
